### src/tapc_pkg.sv
// tapc_pkg: shared types and codes for the two-axle pressure preset controller.
// No dependencies.
`timescale 1ns / 1ps

package tapc_pkg;

  localparam int GOAL_W    = 14;
  localparam int TOL_W     = 12;
  localparam int MARGIN_W  = 12;
  localparam int TICK_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int FRAC_BITS = 4;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_START  = 2'd1,
    FUNC_TOGGLE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    DRV_HOLD = 2'd0,
    DRV_UP   = 2'd1,
    DRV_DOWN = 2'd2
  } drive_t;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_RUNNING  = 3'd1,
    ST_PAUSED   = 3'd2,
    ST_RESUMED  = 3'd3,
    ST_COMPLETE = 3'd4,
    ST_TIMEOUT  = 3'd5,
    ST_STARTED  = 3'd6,
    ST_IGNORED  = 3'd7
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOLERANCE     = 2'd0,
    REG_SUPPLY_MARGIN = 2'd1,
    REG_TIMEOUT       = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [TOL_W-1:0]    tolerance;
    logic [MARGIN_W-1:0] supply_margin;
    logic [TICK_W-1:0]   timeout_ticks;
  } cfg_t;

  typedef struct packed {
    drive_t drive;
    logic   reached;
    logic   need;
  } axle_res_t;

  typedef struct packed {
    drive_t  front_drive;
    drive_t  rear_drive;
    logic    compressor_on;
    status_t status;
  } result_t;

endpackage

### src/tapc_axle.sv
// tapc_axle: dead-band regulation compare for one axle.
// Depends on tapc_pkg.
`timescale 1ns / 1ps

module tapc_axle import tapc_pkg::*; #(
  parameter int ADC_BITS = 10
) (
  input  logic [ADC_BITS-1:0] sample,
  input  logic [ADC_BITS-1:0] tank,
  input  logic [GOAL_W-1:0]   goal,
  input  logic                reached,
  input  cfg_t                cfg,
  output axle_res_t           res
);

  localparam int QW = ADC_BITS + FRAC_BITS;
  localparam int CW = (QW + 1 > GOAL_W + 1) ? QW + 1 : GOAL_W + 1;

  logic [CW-1:0] p_q4;
  logic [CW-1:0] t_q4;
  logic [CW-1:0] goal_x;
  logic [CW-1:0] tol_x;
  logic [CW-1:0] mrg_x;
  logic          low;
  logic          high;

  assign p_q4   = CW'({sample, {FRAC_BITS{1'b0}}});
  assign t_q4   = CW'({tank, {FRAC_BITS{1'b0}}});
  assign goal_x = CW'(goal);
  assign tol_x  = CW'(cfg.tolerance);
  assign mrg_x  = CW'(cfg.supply_margin);

  // goal - tol < 0 can never satisfy p + tol < goal
  assign low  = (p_q4 + tol_x) < goal_x;
  assign high = p_q4 > (goal_x + tol_x);

  always_comb begin
    res = '{drive: DRV_HOLD, reached: reached, need: 1'b0};
    if (!reached) begin
      if (low) begin
        res.drive = DRV_UP;
        res.need  = t_q4 < (goal_x + mrg_x);
      end else if (high) begin
        res.drive = DRV_DOWN;
      end else begin
        res.reached = 1'b1;
      end
    end
  end

endmodule

### src/tapc_ctrl.sv
// tapc_ctrl: preset state, tick counter and per-transaction update.
// Depends on tapc_pkg and tapc_axle.
`timescale 1ns / 1ps

module tapc_ctrl import tapc_pkg::*; #(
  parameter int ADC_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [1:0]          func,
  input  logic [ADC_BITS-1:0] front_sample,
  input  logic [ADC_BITS-1:0] rear_sample,
  input  logic [ADC_BITS-1:0] tank_sample,
  input  logic [GOAL_W-1:0]   goal_front,
  input  logic [GOAL_W-1:0]   goal_rear,
  input  cfg_t                cfg,
  output result_t             result
);

  logic              active, active_next;
  logic              paused, paused_next;
  logic [GOAL_W-1:0] front_goal, front_goal_next;
  logic [GOAL_W-1:0] rear_goal, rear_goal_next;
  logic              front_reached, front_reached_next;
  logic              rear_reached, rear_reached_next;
  logic [TICK_W-1:0] tick_count, tick_count_next;
  drive_t            front_valve, front_valve_next;
  drive_t            rear_valve, rear_valve_next;
  logic              compressor, compressor_next;
  logic [TICK_W-1:0] tick_inc;
  status_t           status;
  axle_res_t         front_res;
  axle_res_t         rear_res;

  tapc_axle #(.ADC_BITS(ADC_BITS)) u_front (
    .sample  (front_sample),
    .tank    (tank_sample),
    .goal    (front_goal),
    .reached (front_reached),
    .cfg     (cfg),
    .res     (front_res)
  );

  tapc_axle #(.ADC_BITS(ADC_BITS)) u_rear (
    .sample  (rear_sample),
    .tank    (tank_sample),
    .goal    (rear_goal),
    .reached (rear_reached),
    .cfg     (cfg),
    .res     (rear_res)
  );

  assign tick_inc = (tick_count != {TICK_W{1'b1}}) ? tick_count + 1'b1 : tick_count;

  always_comb begin
    active_next        = active;
    paused_next        = paused;
    front_goal_next    = front_goal;
    rear_goal_next     = rear_goal;
    front_reached_next = front_reached;
    rear_reached_next  = rear_reached;
    tick_count_next    = tick_count;
    front_valve_next   = front_valve;
    rear_valve_next    = rear_valve;
    compressor_next    = compressor;
    status             = ST_IDLE;
    case (func)
      FUNC_TICK: begin
        if (active) begin
          tick_count_next = tick_inc;
          if (paused) begin
            status = ST_PAUSED;
          end else if (tick_inc >= cfg.timeout_ticks) begin
            front_valve_next = DRV_HOLD;
            rear_valve_next  = DRV_HOLD;
            compressor_next  = 1'b0;
            active_next      = 1'b0;
            status           = ST_TIMEOUT;
          end else begin
            front_valve_next   = front_res.drive;
            rear_valve_next    = rear_res.drive;
            front_reached_next = front_res.reached;
            rear_reached_next  = rear_res.reached;
            compressor_next    = front_res.need | rear_res.need;
            if (front_res.reached && rear_res.reached) begin
              front_valve_next = DRV_HOLD;
              rear_valve_next  = DRV_HOLD;
              compressor_next  = 1'b0;
              active_next      = 1'b0;
              status           = ST_COMPLETE;
            end else begin
              status = ST_RUNNING;
            end
          end
        end
      end
      FUNC_START: begin
        front_goal_next    = goal_front;
        rear_goal_next     = goal_rear;
        active_next        = 1'b1;
        paused_next        = 1'b0;
        front_reached_next = 1'b0;
        rear_reached_next  = 1'b0;
        tick_count_next    = '0;
        status             = ST_STARTED;
      end
      FUNC_TOGGLE: begin
        if (active) begin
          paused_next = !paused;
          if (!paused) begin
            front_valve_next = DRV_HOLD;
            rear_valve_next  = DRV_HOLD;
            compressor_next  = 1'b0;
            status           = ST_PAUSED;
          end else begin
            status = ST_RESUMED;
          end
        end else begin
          status = ST_IGNORED;
        end
      end
      default: begin
        status = ST_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      paused        <= 1'b0;
      front_goal    <= '0;
      rear_goal     <= '0;
      front_reached <= 1'b0;
      rear_reached  <= 1'b0;
      tick_count    <= '0;
      front_valve   <= DRV_HOLD;
      rear_valve    <= DRV_HOLD;
      compressor    <= 1'b0;
    end else if (step) begin
      active        <= active_next;
      paused        <= paused_next;
      front_goal    <= front_goal_next;
      rear_goal     <= rear_goal_next;
      front_reached <= front_reached_next;
      rear_reached  <= rear_reached_next;
      tick_count    <= tick_count_next;
      front_valve   <= front_valve_next;
      rear_valve    <= rear_valve_next;
      compressor    <= compressor_next;
    end
  end

  assign result = '{front_drive: front_valve_next, rear_drive: rear_valve_next,
                    compressor_on: compressor_next, status: status};

endmodule

### src/two_axle_pressure_preset_controller.sv
// two_axle_pressure_preset_controller: top level with input register, config
// registers and result register. Depends on tapc_pkg and tapc_ctrl.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   in      | in_valid/in_ready   | func, front/rear/tank_sample, goal_front/rear
//   out     | out_valid/out_ready | front_drive, rear_drive, compressor_on, status
//   cfg     | cfg_wr_en           | cfg_idx, cfg_data
//
// The input register takes a transaction at its accepting edge; once the result
// register is empty or being read, the compare and state update run from the
// input register into the result register, which then raises out_valid. One transaction
// per cycle while out_ready stays high; the state update is combinational.
// Reset (rst, synchronous) clears the preset state and both valid flags.
// A stalled result holds the input register; in_ready drops once both are full.
`timescale 1ns / 1ps

module two_axle_pressure_preset_controller import tapc_pkg::*; #(
  parameter int ADC_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           func,
  input  logic [ADC_BITS-1:0]  front_sample,
  input  logic [ADC_BITS-1:0]  rear_sample,
  input  logic [ADC_BITS-1:0]  tank_sample,
  input  logic [GOAL_W-1:0]    goal_front,
  input  logic [GOAL_W-1:0]    goal_rear,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           front_drive,
  output logic [1:0]           rear_drive,
  output logic                 compressor_on,
  output logic [2:0]           status,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic                s1_valid;
  logic [1:0]          s1_func;
  logic [ADC_BITS-1:0] s1_front;
  logic [ADC_BITS-1:0] s1_rear;
  logic [ADC_BITS-1:0] s1_tank;
  logic [GOAL_W-1:0]   s1_goal_front;
  logic [GOAL_W-1:0]   s1_goal_rear;
  logic                advance;
  cfg_t                cfg;
  result_t             result;
  result_t             res_q;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tolerance     <= TOL_W'(22);
      cfg.supply_margin <= MARGIN_W'(88);
      cfg.timeout_ticks <= TICK_W'(300);
    end else if (cfg_wr_en) begin
      case (cfg_idx)
        REG_TOLERANCE:     cfg.tolerance     <= cfg_data[TOL_W-1:0];
        REG_SUPPLY_MARGIN: cfg.supply_margin <= cfg_data[MARGIN_W-1:0];
        REG_TIMEOUT:       cfg.timeout_ticks <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_func       <= func;
      s1_front      <= front_sample;
      s1_rear       <= rear_sample;
      s1_tank       <= tank_sample;
      s1_goal_front <= goal_front;
      s1_goal_rear  <= goal_rear;
    end
  end

  tapc_ctrl #(.ADC_BITS(ADC_BITS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .func         (s1_func),
    .front_sample (s1_front),
    .rear_sample  (s1_rear),
    .tank_sample  (s1_tank),
    .goal_front   (s1_goal_front),
    .goal_rear    (s1_goal_rear),
    .cfg          (cfg),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= result;
    end
  end

  assign front_drive   = res_q.front_drive;
  assign rear_drive    = res_q.rear_drive;
  assign compressor_on = res_q.compressor_on;
  assign status        = res_q.status;

endmodule

### src/tapc_checker.sv
// tapc_checker: port-level assertions for the preset controller, bound to the top.
// Depends on tapc_pkg and two_axle_pressure_preset_controller.
`timescale 1ns / 1ps

module tapc_checker import tapc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] front_drive,
  input logic [1:0] rear_drive,
  input logic       compressor_on,
  input logic [2:0] status
);

  logic all_off;

  assign all_off = (front_drive == DRV_HOLD) && (rear_drive == DRV_HOLD) && !compressor_on;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(front_drive) && $stable(rear_drive)
      && $stable(compressor_on) && $stable(status))
    else $error("stalled result changed");

  a_off_when_stopped: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_IDLE || status == ST_PAUSED || status == ST_COMPLETE
      || status == ST_TIMEOUT) |-> all_off)
    else $error("drive active while stopped");

  a_compressor_inflate: assert property (@(posedge clk) disable iff (rst)
    out_valid && compressor_on |-> front_drive == DRV_UP || rear_drive == DRV_UP)
    else $error("compressor on without inflating axle");

endmodule

bind two_axle_pressure_preset_controller tapc_checker u_tapc_checker (.*);

### tb/two_axle_pressure_preset_controller_test.sv
// Self-checking testbench for two_axle_pressure_preset_controller: directed and
// random control ticks, starts and pause toggles against an in-bench valve predictor.
// Depends on tapc_pkg and the controller RTL.
`timescale 1ns / 1ps

module two_axle_pressure_preset_controller_test;
  import tapc_pkg::*;

  localparam int ADC_W = 10;
  localparam logic [ADC_W-1:0] ADC_MAX = '1;
  localparam logic [GOAL_W-1:0] GOAL_MAX = '1;
  localparam int LATENCY = 2;
  localparam int HOLD_CYCLES = 120;
  localparam int LIMIT_CYCLES = 500000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]       fn;
    logic [ADC_W-1:0] fs;
    logic [ADC_W-1:0] rs;
    logic [ADC_W-1:0] ts;
    logic [GOAL_W-1:0] gf;
    logic [GOAL_W-1:0] gr;
  } preset_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = '0;
  logic [ADC_W-1:0] front_sample = '0;
  logic [ADC_W-1:0] rear_sample = '0;
  logic [ADC_W-1:0] tank_sample = '0;
  logic [GOAL_W-1:0] goal_front = '0;
  logic [GOAL_W-1:0] goal_rear = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] front_drive;
  logic [1:0] rear_drive;
  logic compressor_on;
  logic [2:0] status;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  two_axle_pressure_preset_controller #(.ADC_BITS(ADC_W)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .front_sample(front_sample), .rear_sample(rear_sample),
    .tank_sample(tank_sample), .goal_front(goal_front), .goal_rear(goal_rear),
    .out_valid(out_valid), .out_ready(out_ready),
    .front_drive(front_drive), .rear_drive(rear_drive),
    .compressor_on(compressor_on), .status(status),
    .cfg_wr_en(cfg_wr_en), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and configuration
  logic [TOL_W-1:0] cfg_tol = 12'd22;
  logic [MARGIN_W-1:0] cfg_margin = 12'd88;
  logic [TICK_W-1:0] cfg_timeout = 16'd300;
  logic run_active = 1'b0;
  logic run_paused = 1'b0;
  logic [GOAL_W-1:0] tgt_front = '0;
  logic [GOAL_W-1:0] tgt_rear = '0;
  logic done_front = 1'b0;
  logic done_rear = 1'b0;
  logic [TICK_W-1:0] tick_cnt = '0;
  drive_t valve_front = DRV_HOLD;
  drive_t valve_rear = DRV_HOLD;
  logic comp_run = 1'b0;

  result_t valve_commands_due[$];
  int error_count = 0;
  int items_sent = 0;
  int cycle_count = 0;
  bit tx_gaps_on = 1'b1;
  logic rx_stalls_on = 1'b1;
  int hold_requests = 0;
  int holds_served = 0;
  int stall_left = 0;

  function automatic void hold_all();
    valve_front = DRV_HOLD;
    valve_rear = DRV_HOLD;
    comp_run = 1'b0;
  endfunction

  function automatic drive_t axle_drive(input int unsigned p, input int unsigned g,
                                        input int unsigned tank, inout logic reached,
                                        inout logic need);
    if (reached) return DRV_HOLD;
    if (p + cfg_tol < g) begin
      if (tank < g + cfg_margin) need = 1'b1;
      return DRV_UP;
    end
    if (p > g + cfg_tol) return DRV_DOWN;
    reached = 1'b1;
    return DRV_HOLD;
  endfunction

  function automatic result_t predict_valve_command(input preset_item_t it);
    result_t r;
    logic need;
    int unsigned pf, pr, pt;
    need = 1'b0;
    pf = int'(it.fs) << FRAC_BITS;
    pr = int'(it.rs) << FRAC_BITS;
    pt = int'(it.ts) << FRAC_BITS;
    r.status = ST_IGNORED;
    case (it.fn)
      FUNC_TICK: begin
        if (!run_active) begin
          r.status = ST_IDLE;
        end else begin
          if (tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
          if (run_paused) begin
            r.status = ST_PAUSED;
          end else if (tick_cnt >= cfg_timeout) begin
            hold_all();
            run_active = 1'b0;
            run_paused = 1'b0;
            r.status = ST_TIMEOUT;
          end else begin
            valve_front = axle_drive(pf, int'(tgt_front), pt, done_front, need);
            valve_rear = axle_drive(pr, int'(tgt_rear), pt, done_rear, need);
            comp_run = need;
            if (done_front && done_rear) begin
              hold_all();
              run_active = 1'b0;
              run_paused = 1'b0;
              r.status = ST_COMPLETE;
            end else begin
              r.status = ST_RUNNING;
            end
          end
        end
      end
      FUNC_START: begin
        tgt_front = it.gf;
        tgt_rear = it.gr;
        run_active = 1'b1;
        run_paused = 1'b0;
        done_front = 1'b0;
        done_rear = 1'b0;
        tick_cnt = '0;
        r.status = ST_STARTED;
      end
      FUNC_TOGGLE: begin
        if (run_active) begin
          run_paused = !run_paused;
          if (run_paused) begin
            hold_all();
            r.status = ST_PAUSED;
          end else begin
            r.status = ST_RESUMED;
          end
        end
      end
      default: r.status = ST_IGNORED;
    endcase
    r.front_drive = valve_front;
    r.rear_drive = valve_rear;
    r.compressor_on = comp_run;
    return r;
  endfunction

  function automatic preset_item_t rand_item(input logic [1:0] fn);
    preset_item_t it;
    it.fn = fn;
    it.fs = ADC_W'($urandom_range(0, ADC_MAX));
    it.rs = ADC_W'($urandom_range(0, ADC_MAX));
    it.ts = ADC_W'($urandom_range(0, ADC_MAX));
    it.gf = GOAL_W'($urandom_range(0, GOAL_MAX));
    it.gr = GOAL_W'($urandom_range(0, GOAL_MAX));
    return it;
  endfunction

  function automatic preset_item_t tick_item(input logic [ADC_W-1:0] fs,
                                             input logic [ADC_W-1:0] rs,
                                             input logic [ADC_W-1:0] ts);
    preset_item_t it;
    it = rand_item(FUNC_TICK);
    it.fs = fs;
    it.rs = rs;
    it.ts = ts;
    return it;
  endfunction

  function automatic preset_item_t start_item(input logic [GOAL_W-1:0] gf,
                                              input logic [GOAL_W-1:0] gr);
    preset_item_t it;
    it = rand_item(FUNC_START);
    it.gf = gf;
    it.gr = gr;
    return it;
  endfunction

  function automatic logic [GOAL_W-1:0] rand_goal();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return GOAL_MAX;
      default: return GOAL_W'($urandom_range(0, GOAL_MAX));
    endcase
  endfunction

  function automatic logic [ADC_W-1:0] sample_near(input logic [GOAL_W-1:0] g);
    int v;
    if ($urandom_range(0, 3) == 0) return ADC_W'($urandom_range(0, ADC_MAX));
    v = int'(g >> FRAC_BITS) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > int'(ADC_MAX)) v = int'(ADC_MAX);
    return ADC_W'(v);
  endfunction

  // Leaves in_valid high after acceptance so back-to-back transactions need
  // no second assignment in the same step.
  task automatic send_item(input preset_item_t it);
    if (tx_gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= it.fn;
    front_sample <= it.fs;
    rear_sample <= it.rs;
    tank_sample <= it.ts;
    goal_front <= it.gf;
    goal_rear <= it.gr;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    valve_commands_due.push_back(predict_valve_command(it));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (valve_commands_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic set_config(input logic [TOL_W-1:0] tol, input logic [MARGIN_W-1:0] margin,
                            input logic [TICK_W-1:0] timeout);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_idx <= REG_TOLERANCE;
    cfg_data <= {4'($urandom_range(0, 15)), tol};
    @(posedge clk);
    cfg_tol = tol;
    cfg_idx <= REG_SUPPLY_MARGIN;
    cfg_data <= {4'($urandom_range(0, 15)), margin};
    @(posedge clk);
    cfg_margin = margin;
    cfg_idx <= REG_TIMEOUT;
    cfg_data <= timeout;
    @(posedge clk);
    cfg_timeout = timeout;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_preset_sequence();
    int n;
    int pick;
    n = 0;
    if ($urandom_range(0, 7) == 0) begin
      send_item(rand_item(2'($urandom_range(0, 3))));
      return;
    end
    send_item(start_item(rand_goal(), rand_goal()));
    while (run_active && n < 30) begin
      pick = $urandom_range(0, 39);
      if (pick < 3) send_item(rand_item(FUNC_TOGGLE));
      else if (pick == 3) send_item(start_item(rand_goal(), rand_goal()));
      else if (pick == 4) send_item(rand_item(FUNC_UNUSED));
      else send_item(tick_item(sample_near(tgt_front), sample_near(tgt_rear),
                               ADC_W'($urandom_range(0, ADC_MAX))));
      n++;
    end
  endtask

  task automatic test_idle_codes();
    send_item(rand_item(FUNC_TICK));
    send_item(rand_item(FUNC_TOGGLE));
    send_item(rand_item(FUNC_UNUSED));
  endtask

  task automatic test_goal_extremes();
    send_item(start_item('0, GOAL_MAX));
    send_item(tick_item('0, '0, '0));
    send_item(tick_item(ADC_MAX, ADC_MAX, ADC_MAX));
    send_item(start_item(GOAL_MAX, '0));
    send_item(tick_item(ADC_MAX, ADC_MAX, ADC_MAX));
    send_item(tick_item('0, '0, ADC_MAX));
  endtask

  task automatic test_pause_resume();
    send_item(start_item(14'd8000, 14'd8000));
    send_item(tick_item('0, ADC_MAX, ADC_MAX));
    send_item(rand_item(FUNC_TOGGLE));
    send_item(rand_item(FUNC_TICK));
    send_item(rand_item(FUNC_UNUSED));
    send_item(rand_item(FUNC_TOGGLE));
    send_item(tick_item('0, '0, '0));
    send_item(start_item(14'd4000, 14'd12000));
    send_item(tick_item('0, '0, '0));
  endtask

  task automatic test_timeouts();
    set_config(12'd22, 12'd88, 16'd0);
    send_item(start_item(GOAL_MAX, GOAL_MAX));
    send_item(tick_item('0, '0, '0));
    set_config('0, '0, 16'd3);
    send_item(start_item(14'd8192, 14'd8192));
    send_item(tick_item(10'd512, 10'd512, '0));
    send_item(start_item(GOAL_MAX, GOAL_MAX));
    send_item(tick_item('0, '0, '0));
    send_item(rand_item(FUNC_TOGGLE));
    send_item(rand_item(FUNC_TICK));
    send_item(rand_item(FUNC_TICK));
    send_item(rand_item(FUNC_TOGGLE));
    send_item(tick_item('0, '0, '0));
    set_config('1, '1, '1);
    send_item(start_item(14'd100, GOAL_MAX));
    send_item(tick_item('0, '0, '0));
  endtask

  // paused ticks keep counting past the limit; the timeout fires only on the
  // first running tick after resume
  task automatic test_paused_timeout();
    set_config(12'd22, 12'd88, 16'd20);
    tx_gaps_on = 1'b0;
    rx_stalls_on <= 1'b0;
    send_item(start_item(GOAL_MAX, GOAL_MAX));
    send_item(rand_item(FUNC_TOGGLE));
    repeat (25) send_item(rand_item(FUNC_TICK));
    send_item(rand_item(FUNC_TOGGLE));
    send_item(tick_item('0, '0, '0));
    wait_drained();
    tx_gaps_on = 1'b1;
    rx_stalls_on <= 1'b1;
  endtask

  task automatic test_backpressure();
    set_config(12'd22, 12'd88, 16'd300);
    tx_gaps_on = 1'b0;
    hold_requests <= hold_requests + 1;
    send_item(start_item(rand_goal(), rand_goal()));
    repeat (40) send_item(tick_item(sample_near(tgt_front), sample_near(tgt_rear),
                                    ADC_W'($urandom_range(0, ADC_MAX))));
    tx_gaps_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_presets();
    int target;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(12'd22, 12'd88, 16'd300);
        1: set_config(TOL_W'($urandom_range(0, 200)), MARGIN_W'($urandom_range(0, 4095)),
                      TICK_W'($urandom_range(5, 40)));
        2: set_config('0, '0, 16'd1);
        3: set_config('1, '1, '1);
        4: set_config(TOL_W'($urandom_range(0, 63)), MARGIN_W'($urandom_range(0, 4095)),
                      TICK_W'($urandom_range(10, 400)));
        default: begin
          set_config(12'd22, 12'd88, 16'd300);
          tx_gaps_on = 1'b0;
          rx_stalls_on <= 1'b0;
        end
      endcase
      target = items_sent + 130;
      while (items_sent < target) run_preset_sequence();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      stall_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (valve_commands_due.size() == 0) begin
        $error("result transaction with no expectation waiting");
        error_count++;
      end else begin
        want = valve_commands_due.pop_front();
        if (front_drive !== want.front_drive) begin
          $error("front_drive expected %0d got %0d", want.front_drive, front_drive);
          error_count++;
        end
        if (rear_drive !== want.rear_drive) begin
          $error("rear_drive expected %0d got %0d", want.rear_drive, rear_drive);
          error_count++;
        end
        if (compressor_on !== want.compressor_on) begin
          $error("compressor_on expected %0d got %0d", want.compressor_on, compressor_on);
          error_count++;
        end
        if (status !== want.status) begin
          $error("status expected %0d got %0d", want.status, status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_idle_codes();
    test_goal_extremes();
    test_pause_resume();
    test_timeouts();
    test_paused_timeout();
    test_backpressure();
    test_random_presets();
    wait_drained();
    repeat (2 * LATENCY + 4) @(posedge clk);
    if (error_count == 0 && valve_commands_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
src/tapc_pkg.sv
src/tapc_axle.sv
src/tapc_ctrl.sv
src/two_axle_pressure_preset_controller.sv
src/tapc_checker.sv
tb/two_axle_pressure_preset_controller_test.sv
